@@ src/mlpobt_pkg.sv @@
// shared types, codes and the tanh table of the perceptron trainer
`timescale 1ns / 1ps
`default_nettype none
package mlpobt_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FWD,
        ST_TANH,
        ST_OMAC,
        ST_PRED,
        ST_UPD_OUT,
        ST_UPD_HID,
        ST_UPD_W,
        ST_DONE
    } state_t;

    localparam logic [1:0] KIND_INFER = 2'd0;
    localparam logic [1:0] KIND_TRAIN = 2'd1;
    localparam logic [1:0] KIND_LOAD  = 2'd2;

    localparam logic [1:0] CFG_RATE_HIDDEN  = 2'd0;
    localparam logic [1:0] CFG_RATE_OUTPUT  = 2'd1;
    localparam logic [1:0] CFG_WEIGHT_LIMIT = 2'd2;

    localparam logic [14:0] RATE_HIDDEN_RST  = 15'd22938;
    localparam logic [14:0] RATE_OUTPUT_RST  = 15'd2294;
    localparam logic [14:0] WEIGHT_LIMIT_RST = 15'd20480;

    localparam int DATA_W    = 16;
    localparam int HID_W     = 13;
    localparam int ACC_W     = 36;
    localparam int OUT_ACC_W = 33;
    localparam int OPA_W     = 32;
    localparam int OPB_W     = 17;
    localparam int PROD_W    = OPA_W + OPB_W;
    localparam int G_W       = 24;
    localparam int NET_W     = 25;

    localparam logic signed [HID_W-1:0] TANH_MAX = 13'sd4093;

    function automatic logic [HID_W-1:0] tanh_lut(input logic [4:0] idx);
        logic [HID_W-1:0] y;
        case (idx)
            5'd0:    y = 13'd0;
            5'd1:    y = 13'd1003;
            5'd2:    y = 13'd1893;
            5'd3:    y = 13'd2602;
            5'd4:    y = 13'd3119;
            5'd5:    y = 13'd3475;
            5'd6:    y = 13'd3707;
            5'd7:    y = 13'd3856;
            5'd8:    y = 13'd3949;
            5'd9:    y = 13'd4006;
            5'd10:   y = 13'd4041;
            5'd11:   y = 13'd4062;
            5'd12:   y = 13'd4076;
            5'd13:   y = 13'd4084;
            5'd14:   y = 13'd4089;
            5'd15:   y = 13'd4091;
            default: y = 13'd4093;
        endcase
        return y;
    endfunction

    // odd, linear between samples every 0.25, flat from 4.0 up
    function automatic logic signed [HID_W-1:0] tanh_q12(input logic signed [NET_W-1:0] net);
        logic [NET_W-1:0] mag;
        logic [HID_W-1:0] y0;
        logic [HID_W-1:0] y1;
        logic [9:0]       diff;
        logic [20:0]      prodd;
        logic [HID_W-1:0] y;
        mag = net[NET_W-1] ? NET_W'(-net) : NET_W'(net);
        y0 = tanh_lut({1'b0, mag[13:10]});
        y1 = tanh_lut(5'({1'b0, mag[13:10]}) + 5'd1);
        diff = 10'(y1 - y0);
        prodd = 21'(diff) * 21'(mag[9:0]) + 21'd512;
        if (mag >= NET_W'(16384)) begin
            y = TANH_MAX;
        end else begin
            y = y0 + 13'(prodd[20:10]);
        end
        return net[NET_W-1] ? -$signed(y) : $signed(y);
    endfunction

endpackage
`default_nettype wire

@@ src/mlp_online_backprop_trainer.sv @@
// A load item writes one weight and gives a result beat; an infer item runs the
// forward pass; a train item adds the output and hidden weight updates. One item is
// in work at a time; the next is taken while the result waits. Every product goes
// through the one shared multiplier, and the weight memories have a registered read.
// Reset (synchronous, aresetn low) clears control, weight valid bits and sets registers.
`timescale 1ns / 1ps
`default_nettype none
module mlp_online_backprop_trainer #(
    parameter int NUM_FEATURES = 3,
    parameter int NUM_HIDDEN   = 4
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // feature_0, feature_1, feature_2, label, weight_index, weight_value, zero pad
    input  wire logic [87:0] s_tdata,
    // kind
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // prediction, error
    output logic [31:0]      m_tdata,
    // saturated
    output logic             m_tuser,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [14:0] cfg_data
);
    import mlpobt_pkg::*;

    localparam int NF       = NUM_FEATURES;
    localparam int NH       = NUM_HIDDEN;
    localparam int HW_DEPTH = NF * NH;
    localparam int HW_AW    = (HW_DEPTH > 1) ? $clog2(HW_DEPTH) : 1;
    localparam int H_AW     = (NH > 1) ? $clog2(NH) : 1;
    localparam int J_AW     = (NF > 1) ? $clog2(NF) : 1;

    function automatic logic [DATA_W:0] sat16(input logic signed [39:0] x);
        logic [DATA_W:0] r;
        if (x > 40'sd32767) begin
            r = {1'b1, 16'h7fff};
        end else if (x < -40'sd32768) begin
            r = {1'b1, 16'h8000};
        end else begin
            r = {1'b0, x[15:0]};
        end
        return r;
    endfunction

    function automatic logic signed [PROD_W-1:0] rnd(input logic signed [PROD_W-1:0] x,
                                                     input int s);
        logic signed [PROD_W:0] t;
        t = $signed({x[PROD_W-1], x}) + $signed((PROD_W + 1)'(1) << (s - 1));
        return PROD_W'(t >>> s);
    endfunction

    state_t state_reg, state_next;
    logic [2:0]       phase_reg;
    logic [H_AW-1:0]  h_reg;
    logic [J_AW-1:0]  j_reg;
    logic [HW_AW-1:0] addr_reg;
    logic [1:0]       kind_reg;
    logic signed [DATA_W-1:0] label_reg;
    logic signed [DATA_W-1:0] feat_reg [NF];
    logic signed [HID_W-1:0]  hid_reg [NH];
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [OUT_ACC_W-1:0] out_acc_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [G_W-1:0]       g_reg;
    logic signed [DATA_W-1:0]    pred_reg;
    logic signed [DATA_W-1:0]    err_reg;
    logic flag_reg;
    logic [14:0] rate_hidden_reg;
    logic [14:0] rate_output_reg;
    logic [14:0] limit_reg;
    logic        m_tvalid_reg;
    logic [DATA_W-1:0] out_pred_reg;
    logic [DATA_W-1:0] out_err_reg;
    logic              out_sat_reg;

    logic [DATA_W-1:0] hw_mem [HW_DEPTH];
    logic [DATA_W-1:0] ow_mem [NH];
    logic [HW_DEPTH-1:0] hw_vld_reg;
    logic [NH-1:0]       ow_vld_reg;
    logic [DATA_W-1:0] hw_rd_reg;
    logic [DATA_W-1:0] ow_rd_reg;
    logic              hw_rdv_reg;
    logic              ow_rdv_reg;

    logic             hw_rd_en, ow_rd_en, hw_we, ow_we;
    logic [HW_AW-1:0] hw_rd_addr, hw_wa;
    logic [H_AW-1:0]  ow_rd_addr, ow_wa;
    logic [DATA_W-1:0] hw_wd, ow_wd;
    logic signed [OPA_W-1:0] op_a;
    logic signed [OPB_W-1:0] op_b;

    logic s_fire;
    logic last_j, last_h;
    logic signed [DATA_W-1:0] feat_in [NF];
    logic [6:0] widx_ext;
    logic load_hw, load_ow;
    logic signed [DATA_W-1:0] hw_eff, ow_eff, feat_cur;
    logic signed [HID_W-1:0]  hid_cur;
    logic signed [NET_W-1:0]  net;
    logic [DATA_W:0] pred_sat, err_sat, w_sat;
    logic signed [PROD_W-1:0] r12, r15, r27;
    logic signed [24:0] w_out;
    logic signed [24:0] lim_s;
    logic [DATA_W-1:0] w_clamp;
    logic              clamp_flag;
    logic signed [ACC_W:0] net_sum;

    assign s_fire    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {out_err_reg, out_pred_reg};
    assign m_tuser   = out_sat_reg;

    assign last_j   = (j_reg == J_AW'(NF - 1));
    assign last_h   = (h_reg == H_AW'(NH - 1));
    assign widx_ext = {3'b000, s_tdata[67:64]};
    assign load_hw  = widx_ext < 7'(HW_DEPTH);
    assign load_ow  = !load_hw && (widx_ext < 7'(HW_DEPTH + NH));
    assign hw_eff   = hw_rdv_reg ? $signed(hw_rd_reg) : '0;
    assign ow_eff   = ow_rdv_reg ? $signed(ow_rd_reg) : '0;
    assign feat_cur = feat_reg[j_reg];
    assign hid_cur  = hid_reg[h_reg];

    always_comb begin
        for (int j = 0; j < NF; j++) begin
            feat_in[j] = (j < 3) ? $signed(s_tdata[16 * (j % 3) +: 16]) : '0;
        end
    end

    // rounding and saturation of the registered product and accumulators
    assign r12      = rnd(prod_reg, 12);
    assign r15      = rnd(prod_reg, 15);
    assign r27      = rnd(prod_reg, 27);
    assign net_sum  = $signed({acc_reg[ACC_W-1], acc_reg}) + (ACC_W + 1)'(2048);
    assign net      = NET_W'(net_sum >>> 12);
    assign pred_sat = sat16(40'(rnd(PROD_W'(out_acc_reg), 12)));
    assign err_sat  = sat16(40'(pred_reg) - 40'(label_reg));
    assign w_sat    = sat16(40'(hw_eff) - 40'(r12));
    assign w_out    = 25'(ow_eff) - 25'(r27);
    assign lim_s    = $signed({10'd0, limit_reg});

    always_comb begin
        clamp_flag = 1'b0;
        w_clamp    = w_out[15:0];
        if (w_out > lim_s) begin
            clamp_flag = 1'b1;
            w_clamp    = {1'b0, limit_reg};
        end else if (w_out < -lim_s) begin
            clamp_flag = 1'b1;
            w_clamp    = 16'(-lim_s);
        end
    end

    always_comb begin
        state_next = state_reg;
        hw_rd_en   = 1'b0;
        ow_rd_en   = 1'b0;
        hw_rd_addr = addr_reg;
        ow_rd_addr = h_reg;
        hw_we      = 1'b0;
        ow_we      = 1'b0;
        hw_wa      = addr_reg;
        ow_wa      = h_reg;
        hw_wd      = w_sat[15:0];
        ow_wd      = w_clamp;
        op_a       = '0;
        op_b       = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser == KIND_LOAD) begin
                        state_next = ST_DONE;
                        hw_we = load_hw;
                        hw_wa = HW_AW'(widx_ext);
                        hw_wd = s_tdata[83:68];
                        ow_we = load_ow;
                        ow_wa = H_AW'(widx_ext - 7'(HW_DEPTH));
                        ow_wd = s_tdata[83:68];
                    end else begin
                        state_next = ST_FWD;
                    end
                end
            end
            ST_FWD: begin
                case (phase_reg)
                    3'd0: hw_rd_en = 1'b1;
                    3'd1: begin
                        op_a = OPA_W'(feat_cur);
                        op_b = OPB_W'(hw_eff);
                    end
                    default: if (last_j) state_next = ST_TANH;
                endcase
            end
            ST_TANH: state_next = ST_OMAC;
            ST_OMAC: begin
                case (phase_reg)
                    3'd0: ow_rd_en = 1'b1;
                    3'd1: begin
                        op_a = OPA_W'(hid_cur);
                        op_b = OPB_W'(ow_eff);
                    end
                    default: state_next = last_h ? ST_PRED : ST_FWD;
                endcase
            end
            ST_PRED: begin
                if (phase_reg != 3'd0) begin
                    state_next = (kind_reg == KIND_TRAIN) ? ST_UPD_OUT : ST_DONE;
                end
            end
            ST_UPD_OUT: begin
                case (phase_reg)
                    3'd0: begin
                        ow_rd_en = 1'b1;
                        op_a = OPA_W'(err_reg);
                        op_b = OPB_W'(hid_cur);
                    end
                    3'd1: begin
                        op_a = OPA_W'(prod_reg);
                        op_b = $signed({2'b00, rate_output_reg});
                    end
                    default: begin
                        ow_we = 1'b1;
                        if (last_h) state_next = ST_UPD_HID;
                    end
                endcase
            end
            ST_UPD_HID: begin
                case (phase_reg)
                    3'd0: begin
                        ow_rd_en = 1'b1;
                        op_a = OPA_W'(hid_cur);
                        op_b = OPB_W'(hid_cur);
                    end
                    3'd2: begin
                        op_a = OPA_W'(g_reg);
                        op_b = OPB_W'(ow_eff);
                    end
                    3'd4: begin
                        op_a = OPA_W'(g_reg);
                        op_b = OPB_W'(err_reg);
                    end
                    3'd6: begin
                        op_a = OPA_W'(g_reg);
                        op_b = $signed({2'b00, rate_hidden_reg});
                    end
                    3'd7: state_next = ST_UPD_W;
                    default: ;
                endcase
            end
            ST_UPD_W: begin
                case (phase_reg)
                    3'd0: hw_rd_en = 1'b1;
                    3'd1: begin
                        op_a = OPA_W'(g_reg);
                        op_b = OPB_W'(feat_cur);
                    end
                    default: begin
                        hw_we = 1'b1;
                        if (last_j) state_next = last_h ? ST_DONE : ST_UPD_HID;
                    end
                endcase
            end
            ST_DONE: if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (hw_we) hw_mem[hw_wa] <= hw_wd;
        if (ow_we) ow_mem[ow_wa] <= ow_wd;
        if (hw_rd_en) begin
            hw_rd_reg  <= hw_mem[hw_rd_addr];
            hw_rdv_reg <= hw_vld_reg[hw_rd_addr];
        end
        if (ow_rd_en) begin
            ow_rd_reg  <= ow_mem[ow_rd_addr];
            ow_rdv_reg <= ow_vld_reg[ow_rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            phase_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
            hw_vld_reg      <= '0;
            ow_vld_reg      <= '0;
            rate_hidden_reg <= RATE_HIDDEN_RST;
            rate_output_reg <= RATE_OUTPUT_RST;
            limit_reg       <= WEIGHT_LIMIT_RST;
        end else begin
            state_reg <= state_next;
            if (hw_we) hw_vld_reg[hw_wa] <= 1'b1;
            if (ow_we) ow_vld_reg[ow_wa] <= 1'b1;
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_RATE_HIDDEN:  rate_hidden_reg <= cfg_data;
                    CFG_RATE_OUTPUT:  rate_output_reg <= cfg_data;
                    CFG_WEIGHT_LIMIT: limit_reg       <= cfg_data;
                    default: ;
                endcase
            end
            if (state_reg == ST_DONE && state_next == ST_IDLE) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:    phase_reg <= '0;
                ST_FWD:     phase_reg <= (phase_reg == 3'd2) ? 3'd0 : phase_reg + 3'd1;
                ST_OMAC:    phase_reg <= (phase_reg == 3'd2) ? 3'd0 : phase_reg + 3'd1;
                ST_UPD_OUT: phase_reg <= (phase_reg == 3'd2) ? 3'd0 : phase_reg + 3'd1;
                ST_UPD_W:   phase_reg <= (phase_reg == 3'd2) ? 3'd0 : phase_reg + 3'd1;
                ST_PRED:    phase_reg <= (phase_reg == 3'd0) ? 3'd1 : 3'd0;
                ST_UPD_HID: phase_reg <= phase_reg + 3'd1;
                default:    phase_reg <= '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= op_a * op_b;
        if (state_reg == ST_DONE && state_next == ST_IDLE) begin
            out_pred_reg <= pred_reg;
            out_err_reg  <= err_reg;
            out_sat_reg  <= flag_reg;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    kind_reg    <= s_tuser;
                    label_reg   <= s_tdata[63:48];
                    for (int j = 0; j < NF; j++) feat_reg[j] <= feat_in[j];
                    flag_reg    <= 1'b0;
                    pred_reg    <= '0;
                    err_reg     <= '0;
                    acc_reg     <= '0;
                    out_acc_reg <= '0;
                    h_reg       <= '0;
                    j_reg       <= '0;
                    addr_reg    <= '0;
                end
            end
            ST_FWD: begin
                if (phase_reg == 3'd2) begin
                    acc_reg <= acc_reg + ACC_W'(prod_reg);
                    if (!last_j) begin
                        j_reg    <= j_reg + J_AW'(1);
                        addr_reg <= addr_reg + HW_AW'(NH);
                    end
                end
            end
            ST_TANH: hid_reg[h_reg] <= tanh_q12(net);
            ST_OMAC: begin
                if (phase_reg == 3'd2) begin
                    out_acc_reg <= out_acc_reg + OUT_ACC_W'(prod_reg);
                    acc_reg     <= '0;
                    j_reg       <= '0;
                    if (last_h) begin
                        h_reg <= '0;
                    end else begin
                        h_reg    <= h_reg + H_AW'(1);
                        addr_reg <= HW_AW'(h_reg) + HW_AW'(1);
                    end
                end
            end
            ST_PRED: begin
                if (phase_reg == 3'd0) begin
                    pred_reg <= pred_sat[15:0];
                    if (pred_sat[16]) flag_reg <= 1'b1;
                end else begin
                    err_reg <= err_sat[15:0];
                    if (err_sat[16]) flag_reg <= 1'b1;
                end
            end
            ST_UPD_OUT: begin
                if (phase_reg == 3'd2) begin
                    if (clamp_flag) flag_reg <= 1'b1;
                    h_reg <= last_h ? '0 : h_reg + H_AW'(1);
                end
            end
            ST_UPD_HID: begin
                case (phase_reg)
                    3'd1: g_reg <= G_W'(4096) - G_W'(r12);
                    3'd3: g_reg <= G_W'(r12);
                    3'd5: g_reg <= G_W'(r12);
                    3'd7: begin
                        g_reg    <= G_W'(r15);
                        j_reg    <= '0;
                        addr_reg <= HW_AW'(h_reg);
                    end
                    default: ;
                endcase
            end
            ST_UPD_W: begin
                if (phase_reg == 3'd2) begin
                    if (w_sat[16]) flag_reg <= 1'b1;
                    if (last_j) begin
                        j_reg <= '0;
                        if (!last_h) h_reg <= h_reg + H_AW'(1);
                    end else begin
                        j_reg    <= j_reg + J_AW'(1);
                        addr_reg <= addr_reg + HW_AW'(NH);
                    end
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_load_done: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_tuser == KIND_LOAD |=> state_reg == ST_DONE)
        else $error("load beat did not go straight to result");
    a_result_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && m_tvalid_reg && !m_tready |=> state_reg == ST_DONE)
        else $error("result overwrote a pending output beat");
    a_phase_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_UPD_HID |-> phase_reg <= 3'd2)
        else $error("phase counter out of range");
    a_no_mem_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        hw_we && hw_rd_en |-> hw_wa != hw_rd_addr)
        else $error("weight read and write hit the same entry");
`endif

endmodule
`default_nettype wire

@@ bench/mlp_online_backprop_trainer_tb.sv @@
// self-checking testbench of the online-trained perceptron with its own fixed-point predictor
`timescale 1ns / 1ps
`default_nettype none
module mlp_online_backprop_trainer_tb;
    import mlpobt_pkg::*;

    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int N_IN = 3;
    localparam int N_HID = 4;
    localparam longint CYCLE_LIMIT = 2000000;

    typedef struct packed {
        logic signed [15:0] prediction;
        logic signed [15:0] error;
        logic               saturated;
    } result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [14:0] cfg_data;

    mlp_online_backprop_trainer DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor state
    longint in_w [N_IN*N_HID];
    longint out_w [N_HID];
    longint lr_hid;
    longint lr_out;
    longint w_limit;
    const longint tanh_pts [17] = '{0, 1003, 1893, 2602, 3119, 3475, 3707, 3856, 3949,
                                    4006, 4041, 4062, 4076, 4084, 4089, 4091, 4093};

    result_t pending_results [$];
    int      fails;
    longint  cycles;
    int      burst_left;
    int      max_gap;
    int      rdy_mode;
    int      long_stall_req;
    int      stall_left;

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint rshift_round(input longint x, input int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip16(input longint x, inout logic flag);
        if (x > 32767) begin
            flag = 1'b1;
            return 32767;
        end
        if (x < -32768) begin
            flag = 1'b1;
            return -32768;
        end
        return x;
    endfunction

    function automatic longint tanh_approx(input longint x);
        longint a;
        longint seg;
        longint y;
        a = (x < 0) ? -x : x;
        if (a >= 16384) begin
            y = tanh_pts[16];
        end else begin
            seg = a >> 10;
            y = tanh_pts[seg] + (((tanh_pts[seg+1] - tanh_pts[seg]) * (a & 1023) + 512) >> 10);
        end
        return (x < 0) ? -y : y;
    endfunction

    function automatic result_t forward_and_train(input logic [1:0] kind, input logic [87:0] d);
        result_t r;
        longint feat [N_IN];
        longint hid [N_HID];
        longint acc;
        longint acc_out;
        longint pred;
        longint err;
        longint w;
        longint g;
        logic flag;
        int idx;
        flag = 1'b0;
        r = '0;
        if (kind == KIND_LOAD) begin
            idx = int'(d[67:64]);
            if (idx < N_IN*N_HID) in_w[idx] = longint'($signed(d[83:68]));
            else if (idx < N_IN*N_HID + N_HID) out_w[idx - N_IN*N_HID] = longint'($signed(d[83:68]));
            return r;
        end
        for (int j = 0; j < N_IN; j++) feat[j] = longint'($signed(d[16*j +: 16]));
        acc_out = 0;
        for (int h = 0; h < N_HID; h++) begin
            acc = 0;
            for (int j = 0; j < N_IN; j++) acc += feat[j] * in_w[j*N_HID + h];
            hid[h] = tanh_approx(rshift_round(acc, 12));
            acc_out += hid[h] * out_w[h];
        end
        pred = clip16(rshift_round(acc_out, 12), flag);
        err = clip16(pred - longint'($signed(d[63:48])), flag);
        if (kind == KIND_TRAIN) begin
            for (int h = 0; h < N_HID; h++) begin
                w = out_w[h] - rshift_round(lr_out * err * hid[h], 27);
                if (w > w_limit) begin
                    w = w_limit;
                    flag = 1'b1;
                end else if (w < -w_limit) begin
                    w = -w_limit;
                    flag = 1'b1;
                end
                out_w[h] = w;
            end
            for (int h = 0; h < N_HID; h++) begin
                g = 4096 - rshift_round(hid[h] * hid[h], 12);
                g = rshift_round(g * out_w[h], 12);
                g = rshift_round(g * err, 12);
                g = rshift_round(g * lr_hid, 15);
                for (int j = 0; j < N_IN; j++) begin
                    idx = j*N_HID + h;
                    in_w[idx] = clip16(in_w[idx] - rshift_round(g * feat[j], 12), flag);
                end
            end
        end
        r.prediction = pred[15:0];
        r.error = err[15:0];
        r.saturated = flag;
        return r;
    endfunction

    // result checker
    always @(posedge aclk) begin
        result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat %h", m_tdata);
                fails++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_tdata[15:0] !== exp_r.prediction) begin
                    $error("prediction exp %0d got %0d", exp_r.prediction, $signed(m_tdata[15:0]));
                    fails++;
                end
                if (m_tdata[31:16] !== exp_r.error) begin
                    $error("error exp %0d got %0d", exp_r.error, $signed(m_tdata[31:16]));
                    fails++;
                end
                if (m_tuser !== exp_r.saturated) begin
                    $error("saturated exp %0d got %0d", exp_r.saturated, m_tuser);
                    fails++;
                end
            end
        end
    end

    // receiver stall pattern and long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (long_stall_req != 0) begin
            m_tready <= 1'b0;
            stall_left <= 600;
            long_stall_req = 0;
        end else begin
            case (rdy_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 9) < 7);
                default: m_tready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] kind, input logic [15:0] f0, input logic [15:0] f1,
                             input logic [15:0] f2, input logic [15:0] label,
                             input logic [3:0] widx, input logic [15:0] wval);
        int gap;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap = (max_gap > 0) ? $urandom_range(1, max_gap) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tdata <= {4'b0, wval, widx, label, f2, f1, f0};
        s_tuser <= kind;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(forward_and_train(kind, {4'b0, wval, widx, label, f2, f1, f0}));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [14:0] val);
        settle();
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_RATE_HIDDEN:  lr_hid = val;
            CFG_RATE_OUTPUT:  lr_out = val;
            CFG_WEIGHT_LIMIT: w_limit = val;
            default: ;
        endcase
    endtask

    function automatic logic [15:0] rand_q(input int wide_pct);
        if ($urandom_range(0, 99) < wide_pct) return 16'($urandom);
        return 16'($urandom_range(0, 16383) - 8192);
    endfunction

    task automatic load_all_weights(input int wide_pct);
        for (int i = 0; i < 16; i++)
            send_item(KIND_LOAD, rand_q(50), rand_q(50), rand_q(50), rand_q(50), i[3:0],
                      16'($urandom_range(0, 12287) - 6144) | ($urandom_range(0, 99) < wide_pct
                      ? 16'($urandom) : 16'h0));
    endtask

    task automatic test_directed();
        // untouched weights read as zero
        send_item(KIND_INFER, 16'h7fff, 16'h8000, 16'h1000, 16'h8000, 4'd0, 16'd0);
        send_item(KIND_TRAIN, 16'h1000, 16'h1000, 16'h1000, 16'h7fff, 4'd0, 16'd0);
        for (int i = 0; i < 16; i++)
            send_item(KIND_LOAD, 16'hffff, 16'h8000, 16'h7fff, 16'h8000, i[3:0],
                      (i < 12) ? 16'h7fff : 16'h5000);
        // saturated prediction and error, tanh flat region
        send_item(KIND_INFER, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 4'hf, 16'hffff);
        send_item(KIND_SPARE, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 4'd0, 16'd0);
        send_item(KIND_TRAIN, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 4'd0, 16'd0);
        send_item(KIND_TRAIN, 16'h0000, 16'h0000, 16'h0400, 16'h7fff, 4'd0, 16'd0);
        send_item(KIND_INFER, 16'h0123, 16'hfedc, 16'h1000, 16'h0000, 4'd0, 16'd0);
        send_item(KIND_TRAIN, 16'h0800, 16'hf800, 16'h1000, 16'h0800, 4'd0, 16'd0);
    endtask

    task automatic run_random(input int n);
        int sel;
        logic [1:0] kind;
        for (int i = 0; i < n; i++) begin
            if (i % 150 == 0) begin
                max_gap = $urandom_range(0, 1) ? 0 : $urandom_range(2, 40);
                rdy_mode = $urandom_range(0, 2);
                load_all_weights(10);
            end
            sel = $urandom_range(0, 99);
            kind = (sel < 8) ? KIND_LOAD : (sel < 40) ? KIND_INFER
                 : (sel < 96) ? KIND_TRAIN : KIND_SPARE;
            send_item(kind, rand_q(15), rand_q(15), rand_q(15), rand_q(15), 4'($urandom),
                      (sel < 4) ? 16'($urandom) : 16'($urandom_range(0, 12287) - 6144));
        end
    endtask

    task automatic test_config_sweep();
        write_reg(CFG_RATE_HIDDEN, 15'd0);
        write_reg(CFG_RATE_OUTPUT, 15'd32767);
        write_reg(CFG_WEIGHT_LIMIT, 15'd0);
        run_random(60);
        write_reg(CFG_RATE_HIDDEN, 15'd32767);
        write_reg(CFG_RATE_OUTPUT, 15'd0);
        write_reg(CFG_WEIGHT_LIMIT, 15'd32767);
        run_random(60);
        write_reg(CFG_RATE_OUTPUT, 15'd32767);
        write_reg(CFG_WEIGHT_LIMIT, 15'd4096);
        run_random(60);
        write_reg(CFG_RATE_HIDDEN, 15'($urandom));
        write_reg(CFG_RATE_OUTPUT, 15'($urandom));
        write_reg(CFG_WEIGHT_LIMIT, 15'($urandom));
        run_random(60);
        write_reg(CFG_RATE_HIDDEN, RATE_HIDDEN_RST);
        write_reg(CFG_RATE_OUTPUT, RATE_OUTPUT_RST);
        write_reg(CFG_WEIGHT_LIMIT, WEIGHT_LIMIT_RST);
    endtask

    task automatic test_backpressure();
        settle();
        max_gap = 0;
        rdy_mode = 0;
        long_stall_req = 1;
        run_random(40);
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        fails = 0;
        cycles = 0;
        burst_left = 0;
        max_gap = 8;
        rdy_mode = 1;
        long_stall_req = 0;
        foreach (in_w[i]) in_w[i] = 0;
        foreach (out_w[i]) out_w[i] = 0;
        lr_hid = RATE_HIDDEN_RST;
        lr_out = RATE_OUTPUT_RST;
        w_limit = WEIGHT_LIMIT_RST;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_backpressure();
        test_config_sweep();
        run_random(540);
        settle();
        if (fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
